@@ rtl/core/lcds_pkg.sv @@
// Shared types, constants and lookup tables of the LED chaser and digit scan counter.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package lcds_pkg;

	localparam int PATTERN_COUNT = 48;
	localparam int DIGITS        = 8;
	localparam int POS_W         = 6;
	localparam int SCAN_W        = 3;
	localparam int CNT_W         = 4;
	localparam int DIGIT_W       = 4;
	localparam int ROM_DEPTH     = 64;

	localparam logic [7:0] TICK_DIVIDE_RESET = 8'd50;
	localparam logic [7:0] PORT_IDLE         = 8'hff;
	localparam logic [3:0] BCD_MAX           = 4'd9;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [DIGITS-1:0] digit_vec_t;

	// Per-tick status from the chase stepper to the counter and output stage.
	typedef struct packed {
		logic stepped;   // LED pattern stepped on this tick
		logic wrapped;   // chase pattern returned to its first entry
	} chase_status_t;

	localparam logic [7:0] CHASE_TABLE [ROM_DEPTH] = '{
		8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f,
		8'h7f, 8'hbf, 8'hdf, 8'hef, 8'hf7, 8'hfb, 8'hfd, 8'hfe,
		8'hfe, 8'hfc, 8'hf8, 8'hf0, 8'he0, 8'hc0, 8'h80,
		8'h80, 8'hc0, 8'he0, 8'hf0, 8'hf8, 8'hfc, 8'hfe, 8'hff,
		8'hef, 8'he7, 8'hc7, 8'hc3, 8'h83, 8'h81, 8'h01, 8'h00,
		8'h7f, 8'h7e, 8'h3e, 8'h3c, 8'h1c, 8'h18, 8'h08, 8'h00,
		8'h00,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
	};

	function automatic logic [7:0] cathode_seg(input digit_t d);
		logic [7:0] seg;
		case (d)
			4'd0:    seg = 8'h3f;
			4'd1:    seg = 8'h06;
			4'd2:    seg = 8'h5b;
			4'd3:    seg = 8'h4f;
			4'd4:    seg = 8'h66;
			4'd5:    seg = 8'h6d;
			4'd6:    seg = 8'h7d;
			4'd7:    seg = 8'h07;
			4'd8:    seg = 8'h7f;
			4'd9:    seg = 8'h6f;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

	function automatic logic [7:0] anode_seg(input digit_t d);
		logic [7:0] seg;
		case (d)
			4'd0:    seg = 8'hc0;
			4'd1:    seg = 8'hf9;
			4'd2:    seg = 8'ha4;
			4'd3:    seg = 8'hb0;
			4'd4:    seg = 8'h99;
			4'd5:    seg = 8'h92;
			4'd6:    seg = 8'h82;
			4'd7:    seg = 8'hf8;
			4'd8:    seg = 8'h80;
			4'd9:    seg = 8'h90;
			default: seg = 8'hff;
		endcase
		return seg;
	endfunction

endpackage

@@ rtl/core/led_chaser_and_digit_scan_counter_unit.sv @@
// LED chaser and multiplexed digit scan counter, top level.
// Input channel: in_valid / in_stall carry one tick bit per transaction. A transaction
// with tick = 0 is taken and changes nothing; tick = 1 produces exactly one result.
// Output channel: out_valid / out_stall carry the LED port, the scanned digit's select
// and segments, the common-anode units port and the two change flags.
// Configuration: cfg_valid / cfg_ready write tick_divide; cfg_ready is always high and
// the register must only be written while no result is pending.
// Result: a result is loaded into the output register as its tick is taken.
// Throughput: one tick per cycle while in_stall is low; all state updates are
// combinational logic between the state registers and the output register.
// Stall: in_stall rises only while a result sits in the output register and the
// receiver stalls it; a tick is taken in the same cycle the held result leaves.
// Reset (arst_n low): divider 50, count and shown digits zero, one shown digit, scan
// position zero, LED and units ports all ones, output register empty.
// Depends on lcds_pkg, lcds_chase, lcds_count and lcds_scan.
module led_chaser_and_digit_scan_counter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] led_pattern,
	output logic       led_changed,
	output logic [7:0] digit_select,
	output logic [7:0] digit_segments,
	output logic [7:0] units_segments,
	output logic       units_changed,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] tick_divide
);

	logic                         in_fire;
	logic                         step;
	logic                         cfg_we;
	lcds_pkg::chase_status_t      status;
	logic [7:0]                   led_next;
	lcds_pkg::digit_vec_t         shown_next;
	logic [lcds_pkg::CNT_W-1:0]   digit_count_next;
	logic [7:0]                   units_next;
	logic [7:0]                   select_next;
	logic [7:0]                   segments_next;
	logic [lcds_pkg::SCAN_W-1:0]  scan_pos;

	logic                         out_valid_q;
	logic [7:0]                   led_pattern_q;
	logic                         led_changed_q;
	logic [7:0]                   digit_select_q;
	logic [7:0]                   digit_segments_q;
	logic [7:0]                   units_segments_q;
	logic                         units_changed_q;

	assign in_stall  = out_valid_q && out_stall;
	assign in_fire   = in_valid && !in_stall;
	assign step      = in_fire && tick;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	lcds_chase u_chase (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (tick_divide),
		.step     (step),
		.led_next (led_next),
		.status   (status)
	);

	lcds_count u_count (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.status           (status),
		.shown_next       (shown_next),
		.digit_count_next (digit_count_next),
		.units_next       (units_next)
	);

	lcds_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.shown         (shown_next),
		.digit_count   (digit_count_next),
		.select_next   (select_next),
		.segments_next (segments_next),
		.scan_pos      (scan_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			led_pattern_q    <= led_next;
			led_changed_q    <= status.stepped;
			digit_select_q   <= select_next;
			digit_segments_q <= segments_next;
			units_segments_q <= units_next;
			units_changed_q  <= status.wrapped;
		end
	end

	assign out_valid      = out_valid_q;
	assign led_pattern    = led_pattern_q;
	assign led_changed    = led_changed_q;
	assign digit_select   = digit_select_q;
	assign digit_segments = digit_segments_q;
	assign units_segments = units_segments_q;
	assign units_changed  = units_changed_q;

	// A relatch of the shown digits only happens on a chase step.
	a_units_implies_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && units_changed |-> led_changed)
		else $error("units relatch without a chase step");

	// Exactly one digit is selected in every result.
	a_select_one_cold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(~digit_select))
		else $error("digit select is not one-cold");

	// A taken tick always leaves a result in the output register.
	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && tick |=> out_valid)
		else $error("accepted tick produced no result");

	// The scan position stays below the current digit count.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> ({1'b0, scan_pos} < $past(digit_count_next)))
		else $error("scan position past digit count");

endmodule

@@ rtl/core/lcds_chase.sv @@
// Tick prescaler, divider register and chase pattern stepper.
// Depends on lcds_pkg for the chase table and the status struct.
module lcds_chase (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [7:0]              cfg_data,
	input  logic                    step,
	output logic [7:0]              led_next,
	output lcds_pkg::chase_status_t status
);

	logic [7:0]                  tick_divide_q;
	logic [7:0]                  prescale_q;
	logic [lcds_pkg::POS_W-1:0]  pos_q;
	logic [7:0]                  led_q;

	logic [7:0]                  pc;
	logic [lcds_pkg::POS_W:0]    np;
	logic [lcds_pkg::POS_W-1:0]  pos_next;
	logic [7:0]                  prescale_next;

	always_comb begin
		pc            = prescale_q + 8'd1;
		np            = {1'b0, pos_q} + 1'b1;
		status        = '0;
		pos_next      = pos_q;
		led_next      = led_q;
		prescale_next = pc;
		if (pc == tick_divide_q) begin
			prescale_next  = '0;
			led_next       = lcds_pkg::CHASE_TABLE[pos_q];
			status.stepped = 1'b1;
			if (np >= (lcds_pkg::POS_W+1)'(lcds_pkg::PATTERN_COUNT)) begin
				pos_next       = '0;
				status.wrapped = 1'b1;
			end else begin
				pos_next = np[lcds_pkg::POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divide_q <= lcds_pkg::TICK_DIVIDE_RESET;
			prescale_q    <= '0;
			pos_q         <= '0;
			led_q         <= lcds_pkg::PORT_IDLE;
		end else begin
			if (cfg_we) begin
				tick_divide_q <= cfg_data;
			end
			if (step) begin
				prescale_q <= prescale_next;
				pos_q      <= pos_next;
				led_q      <= led_next;
			end
		end
	end

endmodule

@@ rtl/core/lcds_count.sv @@
// BCD event counter with the latched display digits and the common-anode units port.
// Depends on lcds_pkg for digit types and segment tables.
module lcds_count (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  lcds_pkg::chase_status_t      status,
	output lcds_pkg::digit_vec_t         shown_next,
	output logic [lcds_pkg::CNT_W-1:0]   digit_count_next,
	output logic [7:0]                   units_next
);

	lcds_pkg::digit_vec_t        count_q;
	lcds_pkg::digit_vec_t        shown_q;
	logic [lcds_pkg::CNT_W-1:0]  digit_count_q;
	logic [7:0]                  units_q;

	lcds_pkg::digit_vec_t        count_inc;
	logic [lcds_pkg::CNT_W-1:0]  nz_cnt;
	logic                        carry;
	logic [lcds_pkg::DIGIT_W:0]  d;

	always_comb begin
		// Number of digits up to the highest nonzero one, at least one.
		nz_cnt = lcds_pkg::CNT_W'(1);
		for (int k = 0; k < lcds_pkg::DIGITS; k++) begin
			if (count_q[k] != '0) begin
				nz_cnt = lcds_pkg::CNT_W'(k + 1);
			end
		end

		// Decimal increment: a digit that reaches ten clears and carries on.
		carry     = 1'b1;
		count_inc = count_q;
		for (int k = 0; k < lcds_pkg::DIGITS; k++) begin
			d = {1'b0, count_q[k]} + 1'b1;
			if (carry) begin
				if (d <= {1'b0, lcds_pkg::BCD_MAX}) begin
					count_inc[k] = d[lcds_pkg::DIGIT_W-1:0];
					carry        = 1'b0;
				end else begin
					count_inc[k] = '0;
				end
			end
		end

		shown_next       = shown_q;
		digit_count_next = digit_count_q;
		units_next       = units_q;
		if (status.wrapped) begin
			for (int k = 0; k < lcds_pkg::DIGITS; k++) begin
				if (lcds_pkg::CNT_W'(k) < nz_cnt) begin
					shown_next[k] = count_q[k];
				end
			end
			digit_count_next = nz_cnt;
			units_next       = lcds_pkg::anode_seg(count_q[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			shown_q       <= '0;
			digit_count_q <= lcds_pkg::CNT_W'(1);
			units_q       <= lcds_pkg::PORT_IDLE;
		end else if (step) begin
			shown_q       <= shown_next;
			digit_count_q <= digit_count_next;
			units_q       <= units_next;
			if (status.wrapped) begin
				count_q <= count_inc;
			end
		end
	end

endmodule

@@ rtl/core/lcds_scan.sv @@
// Digit scan position and the select and common-cathode segment drive of the scanned digit.
// Depends on lcds_pkg for digit types and the cathode segment table.
module lcds_scan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  lcds_pkg::digit_vec_t         shown,
	input  logic [lcds_pkg::CNT_W-1:0]   digit_count,
	output logic [7:0]                   select_next,
	output logic [7:0]                   segments_next,
	output logic [lcds_pkg::SCAN_W-1:0]  scan_pos
);

	logic [lcds_pkg::SCAN_W-1:0] scan_q;
	logic [lcds_pkg::SCAN_W:0]   s_inc;

	assign scan_pos      = scan_q;
	assign select_next   = ~(8'h80 >> scan_q);
	assign segments_next = lcds_pkg::cathode_seg(shown[scan_q]);
	assign s_inc         = {1'b0, scan_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (step) begin
			// Wrap whenever the advanced position reaches or passes the digit count.
			if (s_inc >= digit_count) begin
				scan_q <= '0;
			end else begin
				scan_q <= s_inc[lcds_pkg::SCAN_W-1:0];
			end
		end
	end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for led_chaser_and_digit_scan_counter_unit.
// Drives tick transactions and divider writes, predicts every result in the bench
// itself and compares it field by field. Depends on the RTL and lcds_pkg only.
`timescale 1ns / 100ps

module tb;

	localparam int CHASE_LEN      = 48;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [7:0] led_pattern;
		logic       led_changed;
		logic [7:0] digit_select;
		logic [7:0] digit_segments;
		logic [7:0] units_segments;
		logic       units_changed;
	} display_t;

	typedef enum logic {ROW_TICK, ROW_DIVIDE} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		logic [7:0] value;
		logic       typed;
		display_t   want;
	} stim_row_t;

	localparam logic [7:0] CHASE_ROM [64] = '{
		8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f,
		8'h7f, 8'hbf, 8'hdf, 8'hef, 8'hf7, 8'hfb, 8'hfd, 8'hfe,
		8'hfe, 8'hfc, 8'hf8, 8'hf0, 8'he0, 8'hc0, 8'h80,
		8'h80, 8'hc0, 8'he0, 8'hf0, 8'hf8, 8'hfc, 8'hfe, 8'hff,
		8'hef, 8'he7, 8'hc7, 8'hc3, 8'h83, 8'h81, 8'h01, 8'h00,
		8'h7f, 8'h7e, 8'h3e, 8'h3c, 8'h1c, 8'h18, 8'h08, 8'h00,
		8'h00,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
	};

	localparam logic [7:0] CATHODE_CODE [16] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] ANODE_CODE [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
	};

	// Early rows are typed in from the reset state; the rest go through the predictor.
	localparam int DIRECTED_ROWS = 28;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_TICK,   8'd1,   1'b1, '{8'hff, 1'b0, 8'h7f, 8'h3f, 8'hff, 1'b0}},
		'{ROW_TICK,   8'd0,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b1, '{8'hff, 1'b0, 8'h7f, 8'h3f, 8'hff, 1'b0}},
		'{ROW_DIVIDE, 8'd3,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b1, '{8'hfe, 1'b1, 8'h7f, 8'h3f, 8'hff, 1'b0}},
		'{ROW_DIVIDE, 8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b1, '{8'hfd, 1'b1, 8'h7f, 8'h3f, 8'hff, 1'b0}},
		'{ROW_TICK,   8'd1,   1'b1, '{8'hfb, 1'b1, 8'h7f, 8'h3f, 8'hff, 1'b0}},
		'{ROW_TICK,   8'd0,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b1, '{8'hf7, 1'b1, 8'h7f, 8'h3f, 8'hff, 1'b0}},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd0,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_DIVIDE, 8'd255, 1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_DIVIDE, 8'd0,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd0,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0},
		'{ROW_DIVIDE, 8'd1,   1'b0, '0},
		'{ROW_TICK,   8'd1,   1'b0, '0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       tick;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] led_pattern;
	logic       led_changed;
	logic [7:0] digit_select;
	logic [7:0] digit_segments;
	logic [7:0] units_segments;
	logic       units_changed;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] tick_divide;

	led_chaser_and_digit_scan_counter_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.tick           (tick),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.led_pattern    (led_pattern),
		.led_changed    (led_changed),
		.digit_select   (digit_select),
		.digit_segments (digit_segments),
		.units_segments (units_segments),
		.units_changed  (units_changed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.tick_divide    (tick_divide)
	);

	// Mirror of the block state.
	logic [7:0]  divide_m;
	logic [7:0]  prescale_m;
	logic [5:0]  chase_pos_m;
	logic [31:0] event_bcd_m;
	logic [3:0]  shown_m [8];
	logic [3:0]  lit_digits_m;
	logic [2:0]  scan_m;
	logic [7:0]  led_m;
	logic [7:0]  units_m;

	display_t expected_display_q [$];
	int       mismatch_count;
	int       quiet_cycles;
	bit       hold_off_req;

	// Advances the mirrored state by one tick and returns what the ports should show.
	function automatic display_t advance_display();
		display_t   r;
		logic [7:0] nxt;
		int         np;
		int         cnt;
		int         s;
		logic       carry;
		logic [3:0] dig;

		r = '0;
		nxt = prescale_m + 8'd1;
		if (nxt == divide_m) begin
			nxt = 8'd0;
			led_m = CHASE_ROM[chase_pos_m];
			r.led_changed = 1'b1;
			np = int'(chase_pos_m) + 1;
			if (np >= CHASE_LEN)
				np = 0;
			chase_pos_m = np[5:0];
			if (np == 0) begin
				cnt = 1;
				for (int k = 0; k < 8; k++)
					if (event_bcd_m[4*k +: 4] != 4'd0)
						cnt = k + 1;
				for (int k = 0; k < cnt; k++)
					shown_m[k] = event_bcd_m[4*k +: 4];
				lit_digits_m = cnt[3:0];
				units_m = ANODE_CODE[shown_m[0]];
				// Decimal increment with ripple carry; all nines roll over to zero.
				carry = 1'b1;
				for (int k = 0; k < 8; k++) begin
					dig = event_bcd_m[4*k +: 4];
					if (carry) begin
						if (dig >= 4'd9) begin
							event_bcd_m[4*k +: 4] = 4'd0;
						end else begin
							event_bcd_m[4*k +: 4] = dig + 4'd1;
							carry = 1'b0;
						end
					end
				end
				r.units_changed = 1'b1;
			end
		end
		prescale_m = nxt;

		r.led_pattern    = led_m;
		r.digit_select   = ~(8'h80 >> scan_m);
		r.digit_segments = CATHODE_CODE[shown_m[scan_m]];
		r.units_segments = units_m;

		s = int'(scan_m) + 1;
		if (s >= int'(lit_digits_m))
			s = 0;
		scan_m = s[2:0];
		return r;
	endfunction

	// Mostly back-to-back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic send_tick(input logic t, input int gap, input logic typed,
			input display_t want);
		display_t d;
		in_valid <= 1'b1;
		tick <= t;
		do @(posedge clk); while (in_stall);
		if (t) begin
			d = advance_display();
			expected_display_q.push_back(typed ? want : d);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			tick <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every outstanding result has drained and the block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_display_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_divide(input logic [7:0] v);
		settle();
		cfg_valid <= 1'b1;
		tick_divide <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		divide_m = v;
	endtask

	always #5 clk = ~clk;

	// Receiver: random stall stretches, plus one long hold-off on request.
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
			repeat (n) @(posedge clk);
			if (hold_off_req) begin
				n = 400;
				hold_off_req = 1'b0;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
			end
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		display_t got;
		display_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{led_pattern, led_changed, digit_select, digit_segments,
				units_segments, units_changed};
			if (expected_display_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result transaction, expected none got %h",
					$time, got);
			end else begin
				want = expected_display_q.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (got.led_pattern !== want.led_pattern)
						$display("%0t: led_pattern expected %02h got %02h",
							$time, want.led_pattern, got.led_pattern);
					if (got.led_changed !== want.led_changed)
						$display("%0t: led_changed expected %b got %b",
							$time, want.led_changed, got.led_changed);
					if (got.digit_select !== want.digit_select)
						$display("%0t: digit_select expected %02h got %02h",
							$time, want.digit_select, got.digit_select);
					if (got.digit_segments !== want.digit_segments)
						$display("%0t: digit_segments expected %02h got %02h",
							$time, want.digit_segments, got.digit_segments);
					if (got.units_segments !== want.units_segments)
						$display("%0t: units_segments expected %02h got %02h",
							$time, want.units_segments, got.units_segments);
					if (got.units_changed !== want.units_changed)
						$display("%0t: units_changed expected %b got %b",
							$time, want.units_changed, got.units_changed);
				end
			end
		end
	end

	// Any transaction on any channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int     remaining;
		int     half;
		logic   t;
		int     phase_len  [10];
		logic [7:0] phase_div [10];

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		tick = 1'b0;
		cfg_valid = 1'b0;
		tick_divide = 8'd0;
		mismatch_count = 0;
		quiet_cycles = 0;
		hold_off_req = 1'b0;
		phase_len = '{200, 300, 200, 300, 200, 150, 200, 150, 100, 150};

		divide_m = lcds_pkg::TICK_DIVIDE_RESET;
		prescale_m = 8'd0;
		chase_pos_m = 6'd0;
		event_bcd_m = 32'd0;
		foreach (shown_m[k])
			shown_m[k] = 4'd0;
		lit_digits_m = 4'd1;
		scan_m = 3'd0;
		led_m = 8'hff;
		units_m = 8'hff;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_DIVIDE)
				write_divide(DIRECTED[i].value);
			else
				send_tick(DIRECTED[i].value[0], pick_gap(), DIRECTED[i].typed,
					DIRECTED[i].want);
		end

		// Divider of one dominates so that the chase wraps and the count relatches
		// often; the extremes and odd values get their own phases.
		phase_div = '{8'd1, 8'd255, 8'd1, 8'd0, 8'd1, 8'($urandom_range(2, 6)), 8'd1,
			8'($urandom_range(1, 255)), 8'd2, 8'd1};
		for (int ph = 0; ph < 10; ph++) begin
			write_divide(phase_div[ph]);
			remaining = phase_len[ph];
			half = remaining / 2;
			while (remaining > 0) begin
				t = ($urandom_range(0, 9) != 0);
				if (ph == 2 && remaining == half)
					hold_off_req = 1'b1;
				// One phase runs with no gaps on the input side at all.
				send_tick(t, (ph == 4) ? 0 : pick_gap(), 1'b0, '0);
				remaining--;
			end
		end

		settle();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ led_chaser_and_digit_scan_counter_unit.f @@
rtl/core/lcds_pkg.sv
rtl/core/lcds_chase.sv
rtl/core/lcds_count.sv
rtl/core/lcds_scan.sv
rtl/core/led_chaser_and_digit_scan_counter_unit.sv
sim/tb.sv
